>>> src/bavg_pkg.sv
// shared constants and types for the block average readout
package bavg_pkg;

  localparam int SAMPLE_W             = 16;
  localparam int SUM_W                = 22;
  localparam int CNT_W                = 6;
  localparam int AVG_W                = 16;
  localparam int DIGIT_W              = 4;
  localparam int TOP_DIGIT_W          = 3;
  localparam int NUM_LOW_DIGITS       = 4;
  localparam int SAMPLES_PER_BLOCK_DEF = 50;

  localparam logic [AVG_W-1:0] AVG_MASK = 16'hFFFC;

  // x / 10 == (x * 52429) >> 19 for every x below 81920
  localparam logic [AVG_W-1:0] DIV10_MUL   = 16'd52429;
  localparam int               DIV10_SHIFT = 19;
  localparam logic [3:0]       RADIX       = 4'd10;

  // beat travelling down the digit pipeline
  typedef struct packed {
    logic [AVG_W-1:0]                            rest;
    logic [AVG_W-1:0]                            average;
    logic [NUM_LOW_DIGITS-1:0][DIGIT_W-1:0]      digits;
  } bcd_stage_t;

endpackage

>>> src/bavg_sample_if.sv
// input channel: one converter sample per beat
interface bavg_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bavg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> src/bavg_result_if.sv
// output channel: block average and its decimal digits per beat
interface bavg_result_if;
  logic                             valid;
  logic                             ready;
  logic [bavg_pkg::AVG_W-1:0]       average;
  logic [bavg_pkg::DIGIT_W-1:0]     digit_ones;
  logic [bavg_pkg::DIGIT_W-1:0]     digit_tens;
  logic [bavg_pkg::DIGIT_W-1:0]     digit_hundreds;
  logic [bavg_pkg::DIGIT_W-1:0]     digit_thousands;
  logic [bavg_pkg::TOP_DIGIT_W-1:0] digit_ten_thousands;

  modport source (output valid, output average, output digit_ones, output digit_tens,
                  output digit_hundreds, output digit_thousands,
                  output digit_ten_thousands, input ready);
  modport sink (input valid, input average, input digit_ones, input digit_tens,
                input digit_hundreds, input digit_thousands,
                input digit_ten_thousands, output ready);
endinterface

>>> src/bavg_accum.sv
// running sum and sample counter, hands out the finished block sum
module bavg_accum #(
  parameter int SAMPLES_PER_BLOCK = bavg_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bavg_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          blk_valid,
  input  logic                          blk_ready,
  output logic [bavg_pkg::SUM_W-1:0]    blk_sum
);

  logic [bavg_pkg::SUM_W-1:0] sum;
  logic [bavg_pkg::SUM_W-1:0] sum_next;
  logic [bavg_pkg::CNT_W-1:0] count;
  logic [bavg_pkg::CNT_W:0]   count_inc;
  logic                       last;
  logic                       take;

  // accept while the block register is free or being emptied
  assign in_ready  = !blk_valid || blk_ready;
  assign take      = in_valid && in_ready;
  assign sum_next  = sum + bavg_pkg::SUM_W'(in_sample);
  assign count_inc = {1'b0, count} + (bavg_pkg::CNT_W + 1)'(1);
  assign last      = (count_inc == (bavg_pkg::CNT_W + 1)'(SAMPLES_PER_BLOCK));

  // control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      blk_valid <= 1'b0;
    end else begin
      if (blk_valid && blk_ready) begin
        blk_valid <= 1'b0;
      end
      if (take) begin
        if (last) begin
          sum       <= '0;
          count     <= '0;
          blk_valid <= 1'b1;
        end else begin
          sum   <= sum_next;
          count <= count_inc[bavg_pkg::CNT_W-1:0];
        end
      end
    end
  end

  // finished block sum
  always_ff @(posedge clk) begin
    if (take && last) begin
      blk_sum <= sum_next;
    end
  end

endmodule

>>> src/bavg_div.sv
// block sum divided by the block length through a reciprocal multiply
module bavg_div #(
  parameter int SAMPLES_PER_BLOCK = bavg_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       blk_valid,
  output logic                       blk_ready,
  input  logic [bavg_pkg::SUM_W-1:0] blk_sum,
  output logic                       avg_valid,
  input  logic                       avg_ready,
  output bavg_pkg::bcd_stage_t       avg_beat
);

  // ceil(2^K / N) with K = sum width + ceil(log2 N) is exact for every sum
  localparam int          LOG_N      = $clog2(SAMPLES_PER_BLOCK);
  localparam int          K          = bavg_pkg::SUM_W + LOG_N;
  localparam int          MUL_W      = bavg_pkg::SUM_W + 1;
  localparam int          PROD_W     = bavg_pkg::SUM_W + MUL_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
  localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

  logic [PROD_W-1:0]          product;
  logic [bavg_pkg::AVG_W-1:0] quotient;
  logic [bavg_pkg::AVG_W-1:0] avg;

  assign blk_ready = !avg_valid || avg_ready;
  assign product   = PROD_W'(blk_sum) * PROD_W'(RECIP);
  assign quotient  = bavg_pkg::AVG_W'(product >> K);
  assign avg       = quotient & bavg_pkg::AVG_MASK;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (blk_ready) begin
      avg_valid <= blk_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (blk_ready && blk_valid) begin
      avg_beat.rest    <= avg;
      avg_beat.average <= avg;
      avg_beat.digits  <= '0;
    end
  end

endmodule

>>> src/bavg_bcd.sv
// decimal split: one digit peeled off per stage, last stage is the output register
module bavg_bcd (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 avg_valid,
  output logic                 avg_ready,
  input  bavg_pkg::bcd_stage_t avg_beat,
  bavg_result_if.source        results
);

  localparam int NS = bavg_pkg::NUM_LOW_DIGITS;

  logic                 st_valid [NS];
  logic                 st_ready [NS+1];
  bavg_pkg::bcd_stage_t st       [NS];

  assign st_ready[NS] = results.ready;
  assign avg_ready    = st_ready[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                       v_in;
    bavg_pkg::bcd_stage_t       b_in;
    bavg_pkg::bcd_stage_t       b_next;
    logic [2*bavg_pkg::AVG_W-1:0] prod;
    logic [bavg_pkg::AVG_W-1:0] q;
    logic [bavg_pkg::AVG_W-1:0] rem;

    if (i == 0) begin : g_first
      assign v_in = avg_valid;
      assign b_in = avg_beat;
    end else begin : g_next
      assign v_in = st_valid[i-1];
      assign b_in = st[i-1];
    end

    assign st_ready[i] = !st_valid[i] || st_ready[i+1];

    // quotient and remainder by ten
    always_comb begin
      prod   = (2*bavg_pkg::AVG_W)'(b_in.rest) * (2*bavg_pkg::AVG_W)'(bavg_pkg::DIV10_MUL);
      q      = bavg_pkg::AVG_W'(prod >> bavg_pkg::DIV10_SHIFT);
      rem    = b_in.rest - (q << 3) - (q << 1);
      b_next = b_in;
      b_next.rest      = q;
      b_next.digits[i] = rem[bavg_pkg::DIGIT_W-1:0];
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i] <= 1'b0;
      end else if (st_ready[i]) begin
        st_valid[i] <= v_in;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (st_ready[i] && v_in) begin
        st[i] <= b_next;
      end
    end
  end

  // output beat from the last stage
  assign results.valid               = st_valid[NS-1];
  assign results.average             = st[NS-1].average;
  assign results.digit_ones          = st[NS-1].digits[0];
  assign results.digit_tens          = st[NS-1].digits[1];
  assign results.digit_hundreds      = st[NS-1].digits[2];
  assign results.digit_thousands     = st[NS-1].digits[3];
  assign results.digit_ten_thousands = st[NS-1].rest[bavg_pkg::TOP_DIGIT_W-1:0];

endmodule

>>> src/block_average_decimal_readout.sv
// top level: block average of converter samples with decimal digit readout
//
//   channel   dir  payload                                     beats
//   samples   in   sample[15:0]                                one per sample
//   results   out  average[15:0], five decimal digits          one per block
//
// A sample beat is taken every cycle; the accumulator adds it in one step.
// After its last sample, a block's result passes the block register, the
// reciprocal multiply stage, then four divide-by-ten digit stages.
// Synchronous reset clears sum, counter and every stage valid.
// A stall on results backs up stage by stage; samples stall only once the
// block register is full and cannot move on.
module block_average_decimal_readout #(
  parameter int SAMPLES_PER_BLOCK = bavg_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bavg_sample_if.sink   samples,
  bavg_result_if.source results
);

  logic                       blk_valid;
  logic                       blk_ready;
  logic [bavg_pkg::SUM_W-1:0] blk_sum;
  logic                       avg_valid;
  logic                       avg_ready;
  bavg_pkg::bcd_stage_t       avg_beat;

  // accumulate samples into blocks
  bavg_accum #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_sample (samples.sample),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_sum   (blk_sum)
  );

  // mean of the block
  bavg_div #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_sum   (blk_sum),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg_beat  (avg_beat)
  );

  // decimal digits and output register
  bavg_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg_beat  (avg_beat),
    .results   (results)
  );

endmodule

>>> dv/block_average_decimal_readout_tb.sv
// testbench for the block average readout: predicts block means and digits, checks each beat
module block_average_decimal_readout_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_LEN     = bavg_pkg::SAMPLES_PER_BLOCK_DEF;
  localparam int DECIMAL_BASE  = 10;
  localparam int RANDOM_ITEMS  = 550;
  localparam int MIN_BLOCKS    = 10;
  localparam int HOLD_CYCLES   = 800;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int SAMPLE_MAX    = (1 << bavg_pkg::SAMPLE_W) - 1;

  // one expected block readout, at the widths of the result channel
  typedef struct packed {
    logic [bavg_pkg::AVG_W-1:0]       average;
    logic [bavg_pkg::DIGIT_W-1:0]     ones;
    logic [bavg_pkg::DIGIT_W-1:0]     tens;
    logic [bavg_pkg::DIGIT_W-1:0]     hundreds;
    logic [bavg_pkg::DIGIT_W-1:0]     thousands;
    logic [bavg_pkg::TOP_DIGIT_W-1:0] ten_thousands;
  } readout_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum logic [1:0] {BLK_UNIFORM, BLK_NARROW, BLK_EXTREMES, BLK_SINGLE_BIT} block_style_t;

  logic clk = 1'b0;
  logic rst;

  bavg_sample_if smp ();
  bavg_result_if res ();

  block_average_decimal_readout #(
    .SAMPLES_PER_BLOCK(BLOCK_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(smp),
    .results(res)
  );

  always #2 clk = ~clk;

  // predictor state: running block sum and sample count
  logic [bavg_pkg::SUM_W-1:0] acc_sum   = '0;
  int unsigned                acc_count = 0;
  readout_t                   pending_readouts[$];

  int unsigned blocks_predicted = 0;
  int unsigned samples_sent     = 0;
  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;
  int unsigned burst_left       = 0;
  bit          gaps_on          = 1'b1;

  rx_mode_t    rx_mode      = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  logic [4:0]  rx_phase     = '0;
  logic        rx_hold      = 1'b0;
  event        hold_off_ev;

  // fold one accepted sample into the block; a full block yields a readout
  task automatic accumulate_sample(input logic [bavg_pkg::SAMPLE_W-1:0] value);
    readout_t                   r;
    logic [bavg_pkg::AVG_W-1:0] mean;
    int unsigned                rest;
    acc_sum   = acc_sum + value;
    acc_count = acc_count + 1;
    if (acc_count == BLOCK_LEN) begin
      mean      = bavg_pkg::AVG_MASK & (acc_sum / BLOCK_LEN);
      r.average = mean;
      rest      = mean;
      r.ones          = bavg_pkg::DIGIT_W'(rest % DECIMAL_BASE);
      rest            = rest / DECIMAL_BASE;
      r.tens          = bavg_pkg::DIGIT_W'(rest % DECIMAL_BASE);
      rest            = rest / DECIMAL_BASE;
      r.hundreds      = bavg_pkg::DIGIT_W'(rest % DECIMAL_BASE);
      rest            = rest / DECIMAL_BASE;
      r.thousands     = bavg_pkg::DIGIT_W'(rest % DECIMAL_BASE);
      rest            = rest / DECIMAL_BASE;
      r.ten_thousands = bavg_pkg::TOP_DIGIT_W'(rest % DECIMAL_BASE);
      pending_readouts.push_back(r);
      blocks_predicted = blocks_predicted + 1;
      acc_sum   = '0;
      acc_count = 0;
    end
  endtask

  // offer one sample beat; a new burst, when due, opens with a random gap if gaps are on
  task automatic send_sample(input logic [bavg_pkg::SAMPLE_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 6);
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    smp.valid  <= 1'b1;
    smp.sample <= value;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    burst_left   = burst_left - 1;
    samples_sent = samples_sent + 1;
    accumulate_sample(value);
  endtask

  // sender goes quiet until every predicted readout has come back
  task automatic pause_until_drained();
    smp.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat ($urandom_range(1, 8)) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_constant_block(input logic [bavg_pkg::SAMPLE_W-1:0] value);
    repeat (BLOCK_LEN) send_sample(value);
  endtask

  // one sample drawn according to the block style
  function automatic logic [bavg_pkg::SAMPLE_W-1:0] pick_sample(block_style_t style,
                                                                 int centre);
    int v;
    case (style)
      BLK_NARROW: begin
        v = centre + $urandom_range(0, 30) - 15;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return bavg_pkg::SAMPLE_W'(v);
      end
      BLK_EXTREMES: return $urandom_range(0, 1) ? bavg_pkg::SAMPLE_W'(SAMPLE_MAX) : '0;
      BLK_SINGLE_BIT: begin
        v = 1 << $urandom_range(0, bavg_pkg::SAMPLE_W - 1);
        return $urandom_range(0, 1) ? bavg_pkg::SAMPLE_W'(v) : ~bavg_pkg::SAMPLE_W'(v);
      end
      default: return bavg_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches = mismatches + 1;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) report(what, want, got);
  endtask

  // directed: silent input gives a zero readout
  task automatic test_zero_block();
    send_constant_block('0);
  endtask

  // directed: full scale, top digit at its largest
  task automatic test_full_scale_block();
    send_constant_block(bavg_pkg::SAMPLE_W'(SAMPLE_MAX));
  endtask

  // directed: a mean whose low bits get cleared, and a sum that does not divide evenly
  task automatic test_truncation();
    send_constant_block(16'd7);
    for (int i = 0; i < BLOCK_LEN; i++) send_sample(bavg_pkg::SAMPLE_W'(i + 3));
  endtask

  // directed: means of 59996 and 9996, nines in the tens, hundreds and thousands digits
  task automatic test_nine_digits();
    send_constant_block(16'd59999);
    send_constant_block(16'd9999);
  endtask

  // directed: alternating bit patterns toggle every sample bit
  task automatic test_bit_patterns();
    for (int i = 0; i < BLOCK_LEN; i++) send_sample((i % 2) ? 16'hAAAA : 16'h5555);
  endtask

  // sender stops mid block and again at a block end until all results are back
  task automatic test_drain_pause();
    repeat (BLOCK_LEN / 2) send_sample(bavg_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    pause_until_drained();
    repeat (BLOCK_LEN - BLOCK_LEN / 2)
      send_sample(bavg_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    pause_until_drained();
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_back_pressure();
    -> hold_off_ev;
    gaps_on = 1'b0;
    repeat (10 * BLOCK_LEN) send_sample(bavg_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    gaps_on = 1'b1;
  endtask

  // random blocks of mixed styles with sender gaps switched on and off
  task automatic test_random_blocks();
    int unsigned  sent_here;
    int unsigned  blocks_here;
    block_style_t style;
    int           centre;
    sent_here   = 0;
    blocks_here = blocks_predicted;
    while (sent_here < RANDOM_ITEMS || blocks_predicted - blocks_here < MIN_BLOCKS) begin
      style   = block_style_t'($urandom_range(0, 3));
      centre  = $urandom_range(0, SAMPLE_MAX);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (BLOCK_LEN) begin
        send_sample(pick_sample(style, centre));
        sent_here = sent_here + 1;
      end
    end
    gaps_on = 1'b1;
  endtask

  // receiver ready pattern, changing its mode every so often
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (rx_hold) begin
      res.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: res.ready <= 1'b1;
        RX_MOSTLY: res.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
        default:   res.ready <= rx_phase[1] ^ rx_phase[3];
      endcase
    end
  end

  // long receiver hold-off, counted here in cycles
  always begin
    @(hold_off_ev);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // compare each result beat with the oldest predicted readout
  always @(posedge clk) begin : check_results
    readout_t want;
    readout_t got;
    if (!rst && res.valid && res.ready) begin
      got.average       = res.average;
      got.ones          = res.digit_ones;
      got.tens          = res.digit_tens;
      got.hundreds      = res.digit_hundreds;
      got.thousands     = res.digit_thousands;
      got.ten_thousands = res.digit_ten_thousands;
      if (pending_readouts.size() == 0) begin
        report("result with nothing expected, average", '0, got.average);
      end else begin
        want = pending_readouts.pop_front();
        compare_field("average", want.average, got.average);
        compare_field("digit_ones", want.ones, got.ones);
        compare_field("digit_tens", want.tens, got.tens);
        compare_field("digit_hundreds", want.hundreds, got.hundreds);
        compare_field("digit_thousands", want.thousands, got.thousands);
        compare_field("digit_ten_thousands", want.ten_thousands, got.ten_thousands);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    smp.valid  = 1'b0;
    smp.sample = '0;
    res.ready  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_zero_block();
    test_full_scale_block();
    test_truncation();
    test_nine_digits();
    test_bit_patterns();
    test_drain_pause();
    test_back_pressure();
    test_random_blocks();

    // wait out the remaining readouts, then idle a while longer for strays
    smp.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readouts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
